/* design/pcms_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcms_pkg
// Shared constants and types for the point chase motion step block.
// ----------------------------------------------------------------------------
package pcms_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_W     = 2;

    typedef enum logic [1:0] {
        CFG_GOAL_X = 2'd0,
        CFG_GOAL_Y = 2'd1,
        CFG_SPEED  = 2'd2,
        CFG_ACCEL  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQRT,
        ST_DIV_X,
        ST_DIV_Y,
        ST_ACC,
        ST_VEL,
        ST_VSQ,
        ST_CLAMP,
        ST_POS,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic diff;
        logic sqrt_start;
        logic div_start_x;
        logic div_start_y;
        logic acc;
        logic vel;
        logic vsq;
        logic clamp;
        logic pos;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

/* design/pcms_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcms_ctrl
// Step sequencer: walks the datapath through one integration step, or skips to output for a report-only request.
// ----------------------------------------------------------------------------
module pcms_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_advance,
    output logic                m_valid,
    input  wire logic           m_ready,
    output pcms_pkg::cmd_t      cmd,
    input  wire pcms_pkg::stat_t stat
);

    pcms_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcms_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pcms_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = s_advance ? pcms_pkg::ST_DIFF : pcms_pkg::ST_OUT;
                end
            end
            pcms_pkg::ST_DIFF:  state_next = pcms_pkg::ST_SQRT;
            pcms_pkg::ST_SQRT: begin
                if (stat.sqrt_done) state_next = pcms_pkg::ST_DIV_X;
            end
            pcms_pkg::ST_DIV_X: begin
                if (stat.div_done) state_next = pcms_pkg::ST_DIV_Y;
            end
            pcms_pkg::ST_DIV_Y: begin
                if (stat.div_done) state_next = pcms_pkg::ST_ACC;
            end
            pcms_pkg::ST_ACC:   state_next = pcms_pkg::ST_VEL;
            pcms_pkg::ST_VEL:   state_next = pcms_pkg::ST_VSQ;
            pcms_pkg::ST_VSQ:   state_next = pcms_pkg::ST_CLAMP;
            pcms_pkg::ST_CLAMP: state_next = pcms_pkg::ST_POS;
            pcms_pkg::ST_POS:   state_next = pcms_pkg::ST_OUT;
            pcms_pkg::ST_OUT: begin
                if (m_ready) state_next = pcms_pkg::ST_IDLE;
            end
            default:            state_next = pcms_pkg::ST_IDLE;
        endcase
    end

    logic prev_sqrt_reg, prev_divx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sqrt_reg <= 1'b0;
            prev_divx_reg <= 1'b0;
        end else begin
            prev_sqrt_reg <= (state_reg == pcms_pkg::ST_SQRT);
            prev_divx_reg <= (state_reg == pcms_pkg::ST_DIV_X);
        end
    end

    always_comb begin
        cmd             = '0;
        s_ready         = (state_reg == pcms_pkg::ST_IDLE);
        m_valid         = (state_reg == pcms_pkg::ST_OUT);
        cmd.diff        = (state_reg == pcms_pkg::ST_DIFF);
        // start pulses: square root and X divide on the first cycle of their states, Y divide as the X divide finishes
        cmd.sqrt_start  = (state_reg == pcms_pkg::ST_SQRT) && !prev_sqrt_reg;
        cmd.div_start_x = (state_reg == pcms_pkg::ST_DIV_X) && !prev_divx_reg;
        cmd.div_start_y = (state_reg == pcms_pkg::ST_DIV_X) && stat.div_done;
        cmd.acc         = (state_reg == pcms_pkg::ST_ACC);
        cmd.vel         = (state_reg == pcms_pkg::ST_VEL);
        cmd.vsq         = (state_reg == pcms_pkg::ST_VSQ);
        cmd.clamp       = (state_reg == pcms_pkg::ST_CLAMP);
        cmd.pos         = (state_reg == pcms_pkg::ST_POS);
    end

endmodule
`default_nettype wire

/* design/pcms_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcms_dp
// Datapath: state registers, bit-serial square root and divider, products.
// ----------------------------------------------------------------------------
module pcms_dp #(
    parameter int FRAC_BITS = pcms_pkg::FRAC_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_valid,
    input  wire logic [pcms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]              cfg_data,
    input  wire pcms_pkg::cmd_t           cmd,
    output pcms_pkg::stat_t               stat,
    output logic signed [31:0]            pos_x,
    output logic signed [31:0]            pos_y,
    output logic signed [31:0]            vel_x,
    output logic signed [31:0]            vel_y
);

    localparam logic [31:0] DT_Q =
        32'(((64'd1 << FRAC_BITS) * 64'd16 + 64'd500) / 64'd1000);
    localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
    localparam int QW = 32 + FRAC_BITS;   // dividend width
    localparam int QCW = $clog2(QW + 1);

    logic signed [31:0] goal_x_reg, goal_y_reg;
    logic [30:0]        speed_reg, accel_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            speed_reg  <= '0;
            accel_reg  <= '0;
        end else if (cfg_valid) begin
            case (pcms_pkg::cfg_idx_t'(cfg_index))
                pcms_pkg::CFG_GOAL_X: goal_x_reg <= cfg_data;
                pcms_pkg::CFG_GOAL_Y: goal_y_reg <= cfg_data;
                pcms_pkg::CFG_SPEED:  speed_reg  <= cfg_data[30:0];
                pcms_pkg::CFG_ACCEL:  accel_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // rounded magnitude product reduction
    function automatic logic [63:0] redq(input logic [63:0] m);
        logic [63:0] r;
        r = (m + HALF) >> FRAC_BITS;
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // difference and halving
    logic [31:0] mx_reg, my_reg;
    logic        nx_reg, ny_reg;
    logic signed [32:0] dxs, dys;
    logic [32:0] amx, amy;
    always_comb begin
        dxs = 33'(goal_x_reg) - 33'(px_reg);
        dys = 33'(goal_y_reg) - 33'(py_reg);
        amx = dxs[32] ? 33'(-dxs) : 33'(dxs);
        amy = dys[32] ? 33'(-dys) : 33'(dys);
    end
    always_ff @(posedge aclk) begin
        if (cmd.diff) begin
            nx_reg <= dxs[32];
            ny_reg <= dys[32];
            if (amx[32] | amx[31] | amy[32] | amy[31]) begin
                mx_reg <= amx[32:1];
                my_reg <= amy[32:1];
            end else begin
                mx_reg <= amx[31:0];
                my_reg <= amy[31:0];
            end
        end
    end

    // square root: one result bit per cycle, squares computed at start
    logic [63:0] rem_reg, res_reg, bit_reg;
    logic        sq_busy_reg;
    logic [63:0] sq_sum;
    assign sq_sum = 64'(mx_reg) * 64'(mx_reg) + 64'(my_reg) * 64'(my_reg);
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_busy_reg <= 1'b0;
        end else if (cmd.sqrt_start) begin
            sq_busy_reg <= 1'b1;
        end else if (sq_busy_reg && bit_reg == 64'd0) begin
            sq_busy_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            rem_reg <= sq_sum;
            res_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end else if (sq_busy_reg && bit_reg != 64'd0) begin
            if (rem_reg >= res_reg + bit_reg) begin
                rem_reg <= rem_reg - (res_reg + bit_reg);
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end
    assign stat.sqrt_done = sq_busy_reg && bit_reg == 64'd0;

    // restoring divider, one quotient bit per cycle
    logic [QW-1:0]  dq_reg;
    logic [32:0]    dr_reg;
    logic [QCW-1:0] dcnt_reg;
    logic           dbusy_reg;
    logic [QW-1:0]  dnum;
    logic [33:0]    dtrial;
    assign dnum   = cmd.div_start_x ? (QW'(mx_reg) << FRAC_BITS)
                                    : (QW'(my_reg) << FRAC_BITS);
    assign dtrial = {dr_reg, dq_reg[QW-1]} - {2'b0, res_reg[31:0]};
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
        end else if (cmd.div_start_x || cmd.div_start_y) begin
            dbusy_reg <= 1'b1;
        end else if (stat.div_done) begin
            dbusy_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.div_start_x || cmd.div_start_y) begin
            dq_reg   <= dnum;
            dr_reg   <= '0;
            dcnt_reg <= '0;
        end else if (dbusy_reg && dcnt_reg != QCW'(QW)) begin
            if (!dtrial[33]) begin
                dr_reg <= dtrial[32:0];
                dq_reg <= {dq_reg[QW-2:0], 1'b1};
            end else begin
                dr_reg <= {dr_reg[31:0], dq_reg[QW-1]};
                dq_reg <= {dq_reg[QW-2:0], 1'b0};
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end
    assign stat.div_done = dbusy_reg && dcnt_reg == QCW'(QW);

    // unit vector magnitudes (<= 1.0)
    logic [FRAC_BITS:0] ux_reg, uy_reg;
    logic [FRAC_BITS:0] qval;
    assign qval = (res_reg[31:0] == 32'd0) ? '0 : dq_reg[FRAC_BITS:0];
    always_ff @(posedge aclk) begin
        if (stat.div_done && !cmd.div_start_y) uy_reg <= qval;
        else if (cmd.div_start_y) ux_reg <= qval;
    end

    // acceleration term times dt, then velocity update
    logic [31:0] ax_reg, ay_reg;
    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            ax_reg <= 32'(redq(64'(accel_reg) * 64'(ux_reg)));
            ay_reg <= 32'(redq(64'(accel_reg) * 64'(uy_reg)));
        end
    end
    logic [31:0] dvx, dvy;
    assign dvx = 32'(redq(64'(ax_reg) * 64'(DT_Q)));
    assign dvy = 32'(redq(64'(ay_reg) * 64'(DT_Q)));

    logic [63:0] vsq_reg;
    logic [31:0] vmx, vmy;
    assign vmx = mag32(vx_reg);
    assign vmy = mag32(vy_reg);

    logic [31:0] cx, cy, pdx, pdy;
    assign cx  = 32'(redq(64'(speed_reg) * 64'(ux_reg)));
    assign cy  = 32'(redq(64'(speed_reg) * 64'(uy_reg)));
    assign pdx = 32'(redq(64'(vmx) * 64'(DT_Q)));
    assign pdy = 32'(redq(64'(vmy) * 64'(DT_Q)));

    always_ff @(posedge aclk) begin
        if (cmd.vsq) begin
            vsq_reg <= 64'(vmx) * 64'(vmx) + 64'(vmy) * 64'(vmy);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            px_reg <= '0;
            py_reg <= '0;
            vx_reg <= '0;
            vy_reg <= '0;
        end else if (cmd.vel) begin
            vx_reg <= sat(34'(vx_reg) + (nx_reg ? -34'(dvx) : 34'(dvx)));
            vy_reg <= sat(34'(vy_reg) + (ny_reg ? -34'(dvy) : 34'(dvy)));
        end else if (cmd.clamp) begin
            if (vsq_reg > 64'(speed_reg) * 64'(speed_reg)) begin
                vx_reg <= nx_reg ? 32'(-cx) : cx;
                vy_reg <= ny_reg ? 32'(-cy) : cy;
            end
        end else if (cmd.pos) begin
            px_reg <= sat(34'(px_reg) + (vx_reg[31] ? -34'(pdx) : 34'(pdx)));
            py_reg <= sat(34'(py_reg) + (vy_reg[31] ? -34'(pdy) : 34'(pdy)));
        end
    end

    assign pos_x = px_reg;
    assign pos_y = py_reg;
    assign vel_x = vx_reg;
    assign vel_y = vy_reg;

endmodule
`default_nettype wire

/* design/point_chase_motion_step.sv */
`default_nettype none
// Sequence: a report-only transaction shows its result in the cycle after accept;
// an advancing step runs the difference, square root, X and Y divide,
// acceleration, velocity, speed square, clamp and position states in order.
// Throughput: one transaction at a time; s_ready is high only while idle.
// Reset: synchronous active-low aresetn clears position, velocity and all
// configuration registers to zero.
// ----------------------------------------------------------------------------
// point_chase_motion_step
// Moves a point mass one 16 ms step toward a configured 2D goal, or only reports its state.
// ----------------------------------------------------------------------------
module point_chase_motion_step #(
    parameter int FRAC_BITS = pcms_pkg::FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [pcms_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_advance,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y
);

    pcms_pkg::cmd_t  cmd;
    pcms_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    pcms_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_advance (s_advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    pcms_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .pos_x     (m_pos_x),
        .pos_y     (m_pos_y),
        .vel_x     (m_vel_x),
        .vel_y     (m_vel_y)
    );

endmodule
`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives step transactions into point_chase_motion_step, predicts each
// reported position and velocity with a local fixed-point model, and compares
// every result in order. Goal, speed and acceleration settings change between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = pcms_pkg::FRAC_BITS_DEF;
    localparam longint DT_Q = ((longint'(1) << FB) * 16 + 500) / 1000;
    localparam longint CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
    } motion_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    pcms_pkg::cfg_idx_t cfg_index = pcms_pkg::CFG_GOAL_X;
    logic [31:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_advance = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_pos_x, m_pos_y, m_vel_x, m_vel_y;

    point_chase_motion_step dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_advance(s_advance),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y),
        .m_vel_x(m_vel_x), .m_vel_y(m_vel_y)
    );

    always #10 aclk = ~aclk;

    // predictor state
    longint goal_x, goal_y, speed_lim, accel_mag;
    longint pos_x, pos_y, vel_x, vel_y;

    logic step_queue[$];
    motion_t expected_motion[$];
    int mismatches = 0;
    longint cycles = 0;
    bit calm = 1'b0;
    int src_gap = 0, sink_gap = 0;

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint mul_q(longint a, longint b);
        longint m;
        m = (mag(a) * mag(b) + (longint'(1) << (FB - 1))) >>> FB;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic motion_t chase_step(logic adv);
        longint dx, dy, ux, uy, ax, ay;
        longint unsigned mx, my, d, vsq, lim;
        motion_t r;
        if (adv) begin
            dx = goal_x - pos_x;
            dy = goal_y - pos_y;
            mx = mag(dx);
            my = mag(dy);
            ux = 0;
            uy = 0;
            if (mx >= (64'd1 << 31) || my >= (64'd1 << 31)) begin
                mx >>= 1;
                my >>= 1;
            end
            d = root_floor(mx * mx + my * my);
            if (d != 0) begin
                ux = longint'((mx << FB) / d);
                uy = longint'((my << FB) / d);
                if (dx < 0) ux = -ux;
                if (dy < 0) uy = -uy;
            end
            ax = mul_q(accel_mag, ux);
            ay = mul_q(accel_mag, uy);
            vel_x = sat32(vel_x + mul_q(ax, DT_Q));
            vel_y = sat32(vel_y + mul_q(ay, DT_Q));
            vsq = longint'(mag(vel_x)) * mag(vel_x) + longint'(mag(vel_y)) * mag(vel_y);
            lim = longint'(speed_lim) * speed_lim;
            if (vsq > lim) begin
                vel_x = mul_q(speed_lim, ux);
                vel_y = mul_q(speed_lim, uy);
            end
            pos_x = sat32(pos_x + mul_q(vel_x, DT_Q));
            pos_y = sat32(pos_y + mul_q(vel_y, DT_Q));
        end
        r.px = pos_x[31:0];
        r.py = pos_y[31:0];
        r.vx = vel_x[31:0];
        r.vy = vel_y[31:0];
        return r;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_motion.push_back(chase_step(s_advance));
                void'(step_queue.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    s_valid <= 1'b0;
                end else if (step_queue.size() > 0) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        src_gap <= $urandom_range(1, 5) - 1;
                        s_valid <= 1'b0;
                    end else begin
                        s_valid <= 1'b1;
                        s_advance <= step_queue[0];
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        motion_t got, exp_m;
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_pos_x, m_pos_y, m_vel_x, m_vel_y};
                if (expected_motion.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %h", got);
                end else begin
                    exp_m = expected_motion.pop_front();
                    if (got !== exp_m) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp px %0d py %0d vx %0d vy %0d, got %0d %0d %0d %0d",
                                     exp_m.px, exp_m.py, exp_m.vx, exp_m.vy,
                                     got.px, got.py, got.vx, got.vy);
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                sink_gap <= $urandom_range(1, 5) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic write_reg(pcms_pkg::cfg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pcms_pkg::CFG_GOAL_X: goal_x = longint'(signed'(val));
            pcms_pkg::CFG_GOAL_Y: goal_y = longint'(signed'(val));
            pcms_pkg::CFG_SPEED:  speed_lim = longint'(val[30:0]);
            pcms_pkg::CFG_ACCEL:  accel_mag = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (step_queue.size() != 0 || s_valid || expected_motion.size() != 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_word(bit wide);
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return wide ? $urandom : $urandom_range(0, 32'h00ff_ffff)
                                  - 32'h0080_0000;
        endcase
    endfunction

    initial begin
        goal_x = 0; goal_y = 0; speed_lim = 0; accel_mag = 0;
        pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // at the goal with zero settings, then report-only
        step_queue.push_back(1'b1);
        step_queue.push_back(1'b0);
        drain();
        // extremes: far goal, max accel, max limit; saturation
        write_reg(pcms_pkg::CFG_GOAL_X, 32'h7fff_ffff);
        write_reg(pcms_pkg::CFG_GOAL_Y, 32'h8000_0000);
        write_reg(pcms_pkg::CFG_SPEED, 32'h7fff_ffff);
        write_reg(pcms_pkg::CFG_ACCEL, 32'h7fff_ffff);
        repeat (10) step_queue.push_back(1'b1);
        step_queue.push_back(1'b0);
        drain();
        // zero limit clamps velocity to zero
        write_reg(pcms_pkg::CFG_SPEED, 32'h0);
        write_reg(pcms_pkg::CFG_GOAL_X, 32'h8000_0000);
        write_reg(pcms_pkg::CFG_GOAL_Y, 32'h7fff_ffff);
        repeat (5) step_queue.push_back(1'b1);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            write_reg(pcms_pkg::CFG_GOAL_X, rand_word(ph % 3 == 0));
            write_reg(pcms_pkg::CFG_GOAL_Y, rand_word(ph % 3 == 0));
            write_reg(pcms_pkg::CFG_SPEED, (ph == 4) ? 32'h0 : rand_word(ph % 2 == 0));
            write_reg(pcms_pkg::CFG_ACCEL, (ph == 5) ? 32'h0 : rand_word(ph % 2 == 1));
            if (ph == 10) calm = 1'b1;
            repeat (50) step_queue.push_back($urandom_range(0, 3) != 0);
            drain();
        end

        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule
